// ----- hw/rtl/pbfl_pkg.sv -----
// Shared types, codes and default constants of the packet buffer free list.
package pbfl_pkg;

    // Default parameter values and fixed field widths.
    localparam int MAX_BUFFERS_DEF = 1024;
    localparam int ADDR_BITS_DEF   = 48;
    localparam int ADDR_FIELD_W    = 48;
    localparam int BYTES_W         = 16;
    localparam int COUNT_W         = 11;
    localparam int TOTAL_W         = 32;
    localparam int IN_TDATA_W      = 56;
    localparam int OUT_TDATA_W     = 176;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_REGION_BASE  = 2'd0;
    localparam logic [1:0] REG_BUFFER_BYTES = 2'd1;
    localparam logic [1:0] REG_BUFFER_COUNT = 2'd2;
    localparam logic [ADDR_FIELD_W-1:0] REGION_BASE_RST  = '0;
    localparam logic [BYTES_W-1:0]      BUFFER_BYTES_RST = 16'd2048;
    localparam logic [COUNT_W-1:0]      BUFFER_COUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_RETURNED   = 3'd0,
        ST_NULL       = 3'd1,
        ST_FOREIGN    = 3'd2,
        ST_MISALIGNED = 3'd3,
        ST_BEYOND     = 3'd4
    } release_status_t;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_PUSH   = 2'd1,
        OP_REJECT = 2'd2,
        OP_QUERY  = 2'd3
    } op_kind_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        op_kind_t        kind;
        release_status_t status;
    } op_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CHECK,
        F_DIV
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CLEAR,
        B_READ
    } back_state_t;

endpackage

// ----- hw/rtl/pbfl_queue.sv -----
// Two-entry queue between the request classifier and the list engine.
module pbfl_queue #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    output logic          valid,
    input  logic          pop,
    output logic [DW-1:0] pop_data
);
    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    level_reg;

    assign full     = (level_reg == 2'd2);
    assign valid    = (level_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 2'd1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ----- hw/rtl/pbfl_front.sv -----
// Request classifier: takes requests, checks release addresses and divides offsets.
module pbfl_front #(
    parameter int MAX_BUFFERS = pbfl_pkg::MAX_BUFFERS_DEF,
    parameter int IW = $clog2(MAX_BUFFERS),
    parameter int LW = $clog2(MAX_BUFFERS + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pbfl_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [pbfl_pkg::ADDR_FIELD_W-1:0]  region_base,
    input  logic [pbfl_pkg::BYTES_W-1:0]       buffer_bytes,
    input  logic [LW-1:0]                      eff_count,
    input  logic [pbfl_pkg::BYTES_W+LW-1:0]    span,
    input  logic                               q_full,
    output logic                               q_push,
    output pbfl_pkg::op_t                      q_op,
    output logic [IW-1:0]                      q_idx
);
    import pbfl_pkg::*;

    localparam int OW = BYTES_W + IW;
    localparam int SW = $clog2(IW + 1);

    front_state_t            state_reg, state_next;
    logic [ADDR_FIELD_W-1:0] addr_reg, addr_next;
    logic [OW-1:0]           rem_reg, rem_next;
    logic [IW-1:0]           quo_reg, quo_next;
    logic [SW-1:0]           step_reg, step_next;

    logic [ADDR_FIELD_W-1:0] offset;
    logic [OW-1:0]           shifted;
    logic                    ge;
    logic [OW-1:0]           rem_new;
    logic [IW-1:0]           quo_new;

    assign offset  = addr_reg - region_base;
    assign shifted = OW'(buffer_bytes) << step_reg;
    assign ge      = (rem_reg >= shifted);
    assign rem_new = ge ? (rem_reg - shifted) : rem_reg;
    assign quo_new = (quo_reg << 1) | IW'(ge);

    // Classification and restoring division, one quotient bit a cycle.
    always_comb begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        s_tready    = 1'b0;
        q_push      = 1'b0;
        q_op.kind   = OP_QUERY;
        q_op.status = ST_RETURNED;
        q_idx       = '0;
        case (state_reg)
            F_IDLE: begin
                s_tready = !q_full;
                if (s_tvalid && !q_full) begin
                    addr_next = s_tdata[ADDR_FIELD_W+1:2];
                    case (cmd_t'(s_tdata[1:0]))
                        CMD_ALLOC: begin
                            q_push    = 1'b1;
                            q_op.kind = OP_ALLOC;
                        end
                        CMD_RELEASE: begin
                            if (s_tdata[ADDR_FIELD_W+1:2] == '0) begin
                                q_push      = 1'b1;
                                q_op.kind   = OP_REJECT;
                                q_op.status = ST_NULL;
                            end else begin
                                state_next = F_CHECK;
                            end
                        end
                        default: begin
                            q_push    = 1'b1;
                            q_op.kind = OP_QUERY;
                        end
                    endcase
                end
            end
            F_CHECK: begin
                if ((addr_reg < region_base) || (64'(offset) >= 64'(span))) begin
                    q_push      = 1'b1;
                    q_op.kind   = OP_REJECT;
                    q_op.status = ST_FOREIGN;
                    state_next  = F_IDLE;
                end else begin
                    rem_next   = OW'(offset);
                    quo_next   = '0;
                    step_next  = SW'(IW - 1);
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                rem_next = rem_new;
                quo_next = quo_new;
                if (step_reg == '0) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                    if (rem_new != '0) begin
                        q_op.kind   = OP_REJECT;
                        q_op.status = ST_MISALIGNED;
                    end else if (LW'(quo_new) >= eff_count) begin
                        q_op.kind   = OP_REJECT;
                        q_op.status = ST_BEYOND;
                    end else begin
                        q_op.kind = OP_PUSH;
                        q_idx     = quo_new;
                    end
                end else begin
                    step_next = step_reg - SW'(1);
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end
endmodule

// ----- hw/rtl/pbfl_back.sv -----
// List engine: link memory, list head, levels, counters and the result register.
module pbfl_back #(
    parameter int MAX_BUFFERS = pbfl_pkg::MAX_BUFFERS_DEF,
    parameter int ADDR_BITS = pbfl_pkg::ADDR_BITS_DEF,
    parameter int IW = $clog2(MAX_BUFFERS),
    parameter int LW = $clog2(MAX_BUFFERS + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               rebuild,
    input  logic [pbfl_pkg::ADDR_FIELD_W-1:0]  region_base,
    input  logic [pbfl_pkg::BYTES_W-1:0]       buffer_bytes,
    input  logic [LW-1:0]                      eff_count,
    input  logic                               q_valid,
    input  pbfl_pkg::op_t                      q_op,
    input  logic [IW-1:0]                      q_idx,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pbfl_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import pbfl_pkg::*;

    localparam int PW = BYTES_W + IW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BUFFERS - 1);

    back_state_t        state_reg, state_next;
    logic [IW-1:0]      clr_reg, clr_next;
    logic [LW-1:0]      head_reg, head_next;
    logic [LW-1:0]      free_reg, free_next;
    logic [LW-1:0]      busy_reg, busy_next;
    logic [TOTAL_W-1:0] alloc_cnt_reg, alloc_cnt_next;
    logic [TOTAL_W-1:0] rel_cnt_reg, rel_cnt_next;
    logic [TOTAL_W-1:0] fb_cnt_reg, fb_cnt_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [LW-1:0] link_mem [MAX_BUFFERS];
    logic [LW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;

    logic                    out_load;
    logic [ADDR_FIELD_W-1:0] o_gaddr;
    logic                    o_granted;
    logic                    o_exhausted;
    release_status_t         o_status;
    logic [ADDR_BITS-1:0]    addr_sum;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign addr_sum = ADDR_BITS'(region_base) + ADDR_BITS'(prod_reg);

    // Sequencing of the clearing pass and of each request.
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        busy_next      = busy_reg;
        alloc_cnt_next = alloc_cnt_reg;
        rel_cnt_next   = rel_cnt_reg;
        fb_cnt_next    = fb_cnt_reg;
        prod_next      = prod_reg;
        q_pop          = 1'b0;
        rd_addr        = head_reg[IW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        out_load       = 1'b0;
        o_gaddr        = '0;
        o_granted      = 1'b0;
        o_exhausted    = 1'b0;
        o_status       = ST_RETURNED;
        case (state_reg)
            B_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = LW'(clr_reg) + LW'(1);
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == LAST_IDX) begin
                    state_next = B_IDLE;
                    free_next  = eff_count;
                end
            end
            B_IDLE: begin
                if (q_valid && (!out_valid_reg || m_tready)) begin
                    q_pop = 1'b1;
                    case (q_op.kind)
                        OP_ALLOC: begin
                            alloc_cnt_next = alloc_cnt_reg + TOTAL_W'(1);
                            if (head_reg < eff_count) begin
                                prod_next  = PW'(head_reg[IW-1:0]) * PW'(buffer_bytes);
                                state_next = B_READ;
                            end else begin
                                out_load    = 1'b1;
                                o_exhausted = 1'b1;
                                fb_cnt_next = fb_cnt_reg + TOTAL_W'(1);
                            end
                        end
                        OP_PUSH: begin
                            rel_cnt_next = rel_cnt_reg + TOTAL_W'(1);
                            mem_we       = 1'b1;
                            mem_waddr    = q_idx;
                            mem_wdata    = head_reg;
                            head_next    = LW'(q_idx);
                            if (free_reg < eff_count) begin
                                free_next = free_reg + LW'(1);
                            end
                            if (busy_reg != '0) begin
                                busy_next = busy_reg - LW'(1);
                            end
                            out_load = 1'b1;
                        end
                        OP_REJECT: begin
                            if (q_op.status != ST_NULL) begin
                                rel_cnt_next = rel_cnt_reg + TOTAL_W'(1);
                            end
                            o_status = q_op.status;
                            out_load = 1'b1;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            B_READ: begin
                head_next = rd_data_reg;
                if (free_reg != '0) begin
                    free_next = free_reg - LW'(1);
                end
                if (busy_reg < eff_count) begin
                    busy_next = busy_reg + LW'(1);
                end
                o_gaddr    = ADDR_FIELD_W'(addr_sum);
                o_granted  = 1'b1;
                out_load   = 1'b1;
                state_next = B_IDLE;
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        // A configuration write restarts the list from scratch.
        if (rebuild) begin
            state_next = B_CLEAR;
            clr_next   = '0;
            head_next  = '0;
            free_next  = '0;
            busy_next  = '0;
        end

        // Result register: loaded with the levels and counters after the update.
        out_valid_next = (out_valid_reg && !m_tready) || out_load;
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_data_next = OUT_TDATA_W'({fb_cnt_next, rel_cnt_next, alloc_cnt_next,
                                          COUNT_W'(busy_next), COUNT_W'(free_next),
                                          o_status, o_exhausted, o_granted, o_gaddr});
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            free_reg      <= '0;
            busy_reg      <= '0;
            alloc_cnt_reg <= '0;
            rel_cnt_reg   <= '0;
            fb_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            busy_reg      <= busy_next;
            alloc_cnt_reg <= alloc_cnt_next;
            rel_cnt_reg   <= rel_cnt_next;
            fb_cnt_reg    <= fb_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    // Link memory with one write port and a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= link_mem[rd_addr];
    end
endmodule

// ----- hw/rtl/packet_buffer_free_list.sv -----
// Top level of the packet buffer free list: configuration registers and the two halves.
// A query, null release or allocate on an empty list is answered after the queue and the list
// engine, a granting allocate after a link read, then head update, a foreign release after the
// region check, and any other non-null release after that check and the bit-serial divider,
// during which the classifier takes no other request. After reset and every configuration
// write a clearing pass rebuilds all MAX_BUFFERS link entries; requests queue until it ends.
module packet_buffer_free_list #(
    parameter int MAX_BUFFERS = pbfl_pkg::MAX_BUFFERS_DEF,
    parameter int ADDR_BITS = pbfl_pkg::ADDR_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: cmd[1:0], buffer_address[49:2], zero fill
    input  logic [pbfl_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: granted_address, granted, exhausted, release_status,
    // free_buffers, busy_buffers, allocate_total, release_total, fallback_total, zero fill
    output logic [pbfl_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_wr_index,
    input  logic [pbfl_pkg::ADDR_FIELD_W-1:0] cfg_wr_data
);
    import pbfl_pkg::*;

    localparam int IW = $clog2(MAX_BUFFERS);
    localparam int LW = $clog2(MAX_BUFFERS + 1);
    localparam int QW = IW + $bits(op_t);

    logic [ADDR_FIELD_W-1:0] region_base_reg;
    logic [BYTES_W-1:0]      buffer_bytes_reg;
    logic [COUNT_W-1:0]      buffer_count_reg;
    logic [BYTES_W+LW-1:0]   span_reg;
    logic [LW-1:0]           eff_count;
    logic                    rebuild;

    logic          q_push, q_full, q_valid, q_pop;
    op_t           f_op, b_op;
    logic [IW-1:0] f_idx, b_idx;
    logic [QW-1:0] b_data;
    logic [OUT_TDATA_W-1:0] back_tdata;

    // Effective pool size: zero when disabled, capped at the storage depth.
    always_comb begin
        if (buffer_bytes_reg == '0) begin
            eff_count = '0;
        end else if (32'(buffer_count_reg) > 32'(MAX_BUFFERS)) begin
            eff_count = LW'(MAX_BUFFERS);
        end else begin
            eff_count = LW'(buffer_count_reg);
        end
    end

    // Only a write to one of the three registers rebuilds the list.
    assign rebuild = cfg_wr_en &&
                     (cfg_wr_index inside {REG_REGION_BASE, REG_BUFFER_BYTES, REG_BUFFER_COUNT});

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg  <= REGION_BASE_RST;
            buffer_bytes_reg <= BUFFER_BYTES_RST;
            buffer_count_reg <= BUFFER_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_REGION_BASE:  region_base_reg  <= cfg_wr_data;
                REG_BUFFER_BYTES: buffer_bytes_reg <= cfg_wr_data[BYTES_W-1:0];
                REG_BUFFER_COUNT: buffer_count_reg <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Region span in bytes, registered after the multiply.
    always_ff @(posedge aclk) begin
        span_reg <= (BYTES_W+LW)'(eff_count) * (BYTES_W+LW)'(buffer_bytes_reg);
    end

    pbfl_front #(
        .MAX_BUFFERS (MAX_BUFFERS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .region_base  (region_base_reg),
        .buffer_bytes (buffer_bytes_reg),
        .eff_count    (eff_count),
        .span         (span_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (f_op),
        .q_idx        (f_idx)
    );

    pbfl_queue #(
        .DW (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_idx, f_op}),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .pop_data  (b_data)
    );

    assign b_op  = b_data[$bits(op_t)-1:0];
    assign b_idx = b_data[QW-1:$bits(op_t)];

    pbfl_back #(
        .MAX_BUFFERS (MAX_BUFFERS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rebuild      (rebuild),
        .region_base  (region_base_reg),
        .buffer_bytes (buffer_bytes_reg),
        .eff_count    (eff_count),
        .q_valid      (q_valid),
        .q_op         (b_op),
        .q_idx        (b_idx),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (back_tdata)
    );

    assign m_tdata = back_tdata;
endmodule
